### rtl/bs_pkg.sv
// ----------------------------------------------------------------------------
// Bitonic sorter package
// Shared widths, register map, control word layout and sequencer step codes.
// ----------------------------------------------------------------------------
package bs_pkg;

    localparam int ELEM_W                = 32;
    localparam int ELEMENT_COUNT_DEFAULT = 16;

    // Configuration port: one 32-bit register per word address
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam int REG_IDX_W     = PADDR_W - 2;
    localparam int REG_SORT_ASC  = 0;

    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_IN,
        WAIT_OUT
    } wait_sel_t;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_LOAD,
        MEM_RD_PAIR,
        MEM_WR_LO,
        MEM_WR_HI,
        MEM_RD_EMIT
    } mem_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_PAIR
    } cnt_op_t;

    typedef enum logic [1:0] {
        LVL_HOLD,
        LVL_CLR,
        LVL_TDEC,
        LVL_NEXT_STAGE
    } lvl_op_t;

    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NOT_LAST_ELEM,
        JC_NOT_LAST_PAIR,
        JC_NOT_T_ZERO,
        JC_NOT_S_LAST
    } jmp_cond_t;

    // Program steps; the last step falls through to the first.
    typedef enum logic [2:0] {
        STEP_LOAD,
        STEP_READ,
        STEP_WR_LO,
        STEP_WR_HI,
        STEP_NEXT_J,
        STEP_NEXT_K,
        STEP_EMIT_RD,
        STEP_EMIT_OUT
    } step_t;

    typedef struct packed {
        wait_sel_t wait_sel;
        mem_op_t   mem_op;
        cnt_op_t   cnt_op;
        lvl_op_t   lvl_op;
        logic      out_load;
        jmp_cond_t jmp_cond;
        step_t     jmp_target;
    } ctrl_t;

    typedef struct packed {
        logic last_elem;
        logic last_pair;
        logic t_zero;
        logic s_last;
        logic cnt_zero;
        logic out_free;
    } status_t;

endpackage

### rtl/bs_if.sv
// ----------------------------------------------------------------------------
// Bitonic sorter stream interfaces
// Valid/ready channels for loaded elements and for sorted result words.
// ----------------------------------------------------------------------------
interface bs_load_if
    import bs_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] element;

    modport source (output valid, output element, input ready);
    modport sink   (input valid, input element, output ready);
endinterface

interface bs_result_if
    import bs_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] sorted_element;
    logic                     final_flag;

    modport source (output valid, output sorted_element, output final_flag, input ready);
    modport sink   (input valid, input sorted_element, input final_flag, output ready);
endinterface

### rtl/bitonic_sorter_unit.sv
// ----------------------------------------------------------------------------
// Bitonic sorter unit
// Loads ELEMENT_COUNT signed words, sorts them with a bitonic network run by a
// microcoded sequencer, then streams the sorted set with the last word flagged.
// ----------------------------------------------------------------------------
// Loading accepts one word per cycle while words are offered. Each
// compare-exchange of the sort needs a read and two writes on the single write
// port of the element memory, and each emitted word needs a read step and an
// output step.
// Reset is asynchronous and active low; afterwards the direction is ascending
// and the unit waits for the first word of a set. No clearing pass is needed.
// ----------------------------------------------------------------------------
module bitonic_sorter_unit
    import bs_pkg::*;
#(
    parameter int ELEMENT_COUNT = ELEMENT_COUNT_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    bs_load_if.sink            load_ch,
    bs_result_if.source        result_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    ctrl_t   ctrl;
    status_t status;
    step_t   step;
    logic    go;
    logic    sort_ascending;

    // The direction register is read only when the final merge runs, so a
    // write during loading still takes effect for the set in progress.
    bs_apb_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .sort_ascending (sort_ascending)
    );

    // The sequencer steps through load, the compare-exchange passes and the
    // emit loop; it stalls only on the two handshakes.
    bs_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .status     (status),
        .load_valid (load_ch.valid),
        .ctrl       (ctrl),
        .go         (go),
        .step       (step)
    );

    bs_datapath #(
        .ELEMENT_COUNT (ELEMENT_COUNT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .go             (go),
        .sort_ascending (sort_ascending),
        .element        (load_ch.element),
        .out_ready      (result_ch.ready),
        .status         (status),
        .out_valid      (result_ch.valid),
        .sorted_element (result_ch.sorted_element),
        .final_flag     (result_ch.final_flag)
    );

    // A word is taken only in the load step; the output register parts the
    // result side from the sequencer, so loading resumes while it still waits.
    assign load_ch.ready = (ctrl.wait_sel == WAIT_IN);

    // Words are accepted only while the program sits in the load step.
    a_load_only_in_load_step: assert property (
        @(posedge clk) disable iff (!rst_n)
        (load_ch.valid && load_ch.ready) |-> (step == STEP_LOAD))
        else $error("word accepted outside the load step");

    // The output register is never overwritten while its word is untaken.
    a_no_result_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        (go && ctrl.out_load) |-> (!result_ch.valid || result_ch.ready))
        else $error("result word overwritten before it was taken");

    // The first compare-exchange pass starts at pair zero.
    a_sort_starts_at_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        ($past(step) == STEP_LOAD && step == STEP_READ) |-> status.cnt_zero)
        else $error("sort pass did not start at the first pair");

    // Leaving the emit loop leaves the flagged final word on the output.
    a_emit_ends_with_final: assert property (
        @(posedge clk) disable iff (!rst_n)
        ($past(step) == STEP_EMIT_OUT && step == STEP_LOAD)
            |-> (result_ch.valid && result_ch.final_flag))
        else $error("emit loop ended without the final word");

endmodule

### rtl/bs_apb_regs.sv
// ----------------------------------------------------------------------------
// Bitonic sorter configuration registers
// APB-style write and read access to the sort direction register.
// ----------------------------------------------------------------------------
module bs_apb_regs
    import bs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic               sort_ascending
);

    logic                 sort_asc_reg;
    logic                 sort_asc_next;
    logic [REG_IDX_W-1:0] reg_index;
    logic                 wr_en;

    assign reg_index = paddr[PADDR_W-1:2];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;

    always_comb
    begin
        sort_asc_next = sort_asc_reg;
        if (wr_en && (reg_index == REG_IDX_W'(REG_SORT_ASC)))
        begin
            sort_asc_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_asc_reg <= 1'b1;
        end
        else
        begin
            sort_asc_reg <= sort_asc_next;
        end
    end

    assign prdata = (reg_index == REG_IDX_W'(REG_SORT_ASC))
                    ? {{(PDATA_W-1){1'b0}}, sort_asc_reg} : '0;
    assign sort_ascending = sort_asc_reg;

endmodule

### rtl/bs_sequencer.sv
// ----------------------------------------------------------------------------
// Bitonic sorter sequencer
// Step counter, control store and jump logic for the sort program.
// ----------------------------------------------------------------------------
module bs_sequencer
    import bs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    input  logic    load_valid,
    output ctrl_t   ctrl,
    output logic    go,
    output step_t   step
);

    step_t step_reg;
    step_t step_next;
    logic  jump;

    // Control store: one word per step.
    always_comb
    begin
        ctrl = '{wait_sel: WAIT_NONE, mem_op: MEM_NONE, cnt_op: CNT_HOLD,
                 lvl_op: LVL_HOLD, out_load: 1'b0, jmp_cond: JC_NEVER,
                 jmp_target: STEP_LOAD};
        case (step_reg)
            STEP_LOAD:
            begin
                ctrl.wait_sel   = WAIT_IN;
                ctrl.mem_op     = MEM_LOAD;
                ctrl.cnt_op     = CNT_INC;
                ctrl.lvl_op     = LVL_CLR;
                ctrl.jmp_cond   = JC_NOT_LAST_ELEM;
                ctrl.jmp_target = STEP_LOAD;
            end
            STEP_READ:
            begin
                ctrl.mem_op = MEM_RD_PAIR;
            end
            STEP_WR_LO:
            begin
                ctrl.mem_op = MEM_WR_LO;
            end
            STEP_WR_HI:
            begin
                ctrl.mem_op     = MEM_WR_HI;
                ctrl.cnt_op     = CNT_PAIR;
                ctrl.jmp_cond   = JC_NOT_LAST_PAIR;
                ctrl.jmp_target = STEP_READ;
            end
            STEP_NEXT_J:
            begin
                ctrl.lvl_op     = LVL_TDEC;
                ctrl.jmp_cond   = JC_NOT_T_ZERO;
                ctrl.jmp_target = STEP_READ;
            end
            STEP_NEXT_K:
            begin
                ctrl.lvl_op     = LVL_NEXT_STAGE;
                ctrl.jmp_cond   = JC_NOT_S_LAST;
                ctrl.jmp_target = STEP_READ;
            end
            STEP_EMIT_RD:
            begin
                ctrl.mem_op = MEM_RD_EMIT;
            end
            STEP_EMIT_OUT:
            begin
                ctrl.wait_sel   = WAIT_OUT;
                ctrl.cnt_op     = CNT_INC;
                ctrl.out_load   = 1'b1;
                ctrl.jmp_cond   = JC_NOT_LAST_ELEM;
                ctrl.jmp_target = STEP_EMIT_RD;
            end
            default:
            begin
                ctrl.jmp_cond = JC_ALWAYS;
            end
        endcase
    end

    always_comb
    begin
        case (ctrl.wait_sel)
            WAIT_IN:  go = load_valid;
            WAIT_OUT: go = status.out_free;
            default:  go = 1'b1;
        endcase
    end

    always_comb
    begin
        case (ctrl.jmp_cond)
            JC_ALWAYS:        jump = 1'b1;
            JC_NOT_LAST_ELEM: jump = !status.last_elem;
            JC_NOT_LAST_PAIR: jump = !status.last_pair;
            JC_NOT_T_ZERO:    jump = !status.t_zero;
            JC_NOT_S_LAST:    jump = !status.s_last;
            default:          jump = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (go)
        begin
            step_next = jump ? ctrl.jmp_target : step_t'(step_reg + 3'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_LOAD;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign step = step_reg;

endmodule

### rtl/bs_datapath.sv
// ----------------------------------------------------------------------------
// Bitonic sorter datapath
// Element memory, pair and level counters, compare-exchange and output word.
// ----------------------------------------------------------------------------
module bs_datapath
    import bs_pkg::*;
#(
    parameter int ELEMENT_COUNT = ELEMENT_COUNT_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctrl_t                    ctrl,
    input  logic                     go,
    input  logic                     sort_ascending,
    input  logic signed [ELEM_W-1:0] element,
    input  logic                     out_ready,
    output status_t                  status,
    output logic                     out_valid,
    output logic signed [ELEM_W-1:0] sorted_element,
    output logic                     final_flag
);

    localparam int LOG_N = $clog2(ELEMENT_COUNT);
    localparam int IDX_W = LOG_N;
    localparam int LVL_W = (LOG_N > 1) ? $clog2(LOG_N) : 1;

    logic signed [ELEM_W-1:0] mem [ELEMENT_COUNT];

    logic [IDX_W-1:0]         cnt_reg, cnt_next;
    logic [LVL_W-1:0]         s_reg, s_next;
    logic [LVL_W-1:0]         t_reg, t_next;
    logic signed [ELEM_W-1:0] rd_a_reg, rd_b_reg;
    logic                     out_valid_reg, out_valid_next;
    logic signed [ELEM_W-1:0] out_data_reg;
    logic                     out_final_reg;

    logic [IDX_W-1:0]         j_bit, low_mask, high_part, pair_lo, pair_hi, dir_sh;
    logic                     up, swap;
    logic                     mem_we, rd_en;
    logic [IDX_W-1:0]         wr_addr, rd_addr_a, rd_addr_b;
    logic signed [ELEM_W-1:0] wr_data;

    // Lower index of the current pair: a zero inserted at bit t of the count.
    always_comb
    begin
        j_bit     = IDX_W'(1) << t_reg;
        low_mask  = j_bit - IDX_W'(1);
        high_part = ((cnt_reg >> t_reg) << t_reg) << 1;
        pair_lo   = high_part | (cnt_reg & low_mask);
        pair_hi   = pair_lo | j_bit;
        dir_sh    = (pair_lo >> s_reg) >> 1;
    end

    assign status.last_elem = (cnt_reg == IDX_W'(ELEMENT_COUNT - 1));
    assign status.last_pair = (cnt_reg == IDX_W'(ELEMENT_COUNT / 2 - 1));
    assign status.t_zero    = (t_reg == '0);
    assign status.s_last    = (s_reg == LVL_W'(LOG_N - 1));
    assign status.cnt_zero  = (cnt_reg == '0);
    assign status.out_free  = !out_valid_reg || out_ready;

    // Blocks of the final size follow the register; smaller ones alternate.
    assign up   = status.s_last ? sort_ascending : !dir_sh[0];
    assign swap = up ? (rd_a_reg > rd_b_reg) : (rd_b_reg > rd_a_reg);

    always_comb
    begin
        mem_we    = 1'b0;
        rd_en     = 1'b0;
        wr_addr   = cnt_reg;
        wr_data   = element;
        rd_addr_a = pair_lo;
        rd_addr_b = pair_hi;
        case (ctrl.mem_op)
            MEM_LOAD:
            begin
                mem_we = go;
            end
            MEM_RD_PAIR:
            begin
                rd_en = go;
            end
            MEM_WR_LO:
            begin
                mem_we  = go;
                wr_addr = pair_lo;
                wr_data = swap ? rd_b_reg : rd_a_reg;
            end
            MEM_WR_HI:
            begin
                mem_we  = go;
                wr_addr = pair_hi;
                wr_data = swap ? rd_a_reg : rd_b_reg;
            end
            MEM_RD_EMIT:
            begin
                rd_en     = go;
                rd_addr_a = cnt_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        s_next   = s_reg;
        t_next   = t_reg;
        if (go)
        begin
            case (ctrl.cnt_op)
                CNT_INC:  cnt_next = cnt_reg + IDX_W'(1);
                CNT_PAIR: cnt_next = status.last_pair ? '0 : cnt_reg + IDX_W'(1);
                default:  cnt_next = cnt_reg;
            endcase
            case (ctrl.lvl_op)
                LVL_CLR:
                begin
                    s_next = '0;
                    t_next = '0;
                end
                LVL_TDEC:
                begin
                    t_next = t_reg - LVL_W'(1);
                end
                LVL_NEXT_STAGE:
                begin
                    s_next = s_reg + LVL_W'(1);
                    t_next = s_reg + LVL_W'(1);
                end
                default:
                begin
                    s_next = s_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (go && ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            s_reg         <= '0;
            t_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            s_reg         <= s_next;
            t_reg         <= t_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && ctrl.out_load)
        begin
            out_data_reg  <= rd_a_reg;
            out_final_reg <= status.last_elem;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sorted_element = out_data_reg;
    assign final_flag     = out_final_reg;

endmodule
